// File: sv/irt_pkg.sv
// Shared types and constants for the interrupt target router.
// Depends on nothing; imported by irt_ram users and the top level.
package irt_pkg;

  localparam int CpuW  = 32;
  localparam int CpuIdxW = 5;
  localparam int CntW  = 6;

  localparam logic [2:0] STATUS_ROUTED      = 3'd0;
  localparam logic [2:0] STATUS_NOT_PENDING = 3'd1;
  localparam logic [2:0] STATUS_MASKED      = 3'd2;
  localparam logic [2:0] STATUS_ZERO_PRIO   = 3'd3;
  localparam logic [2:0] STATUS_ACTIVE      = 3'd4;
  localparam logic [2:0] STATUS_NO_TARGET   = 3'd5;

  localparam logic REG_CPU_COUNT = 1'b0;

  typedef struct packed {
    logic [7:0]      source_index;
    logic            pending;
    logic            masked;
    logic [3:0]      priority_req;
    logic            active;
    logic            distributed;
    logic [CpuW-1:0] dest_mask;
  } in_item_t;

  typedef struct packed {
    logic [CpuW-1:0] deliver_mask;
    logic [2:0]      status;
  } out_item_t;

endpackage

// File: sv/irt_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
// No dependencies.
module irt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/interrupt_target_router.sv
// Interrupt target router top level: request register, routing logic, result register.
// Depends on irt_pkg and irt_ram (per-source last CPU store).
//
//  channel | ports                          | beat
//  in      | in_valid/in_ready, in_data     | one routing request (in_item_t)
//  out     | out_valid/out_ready, out_data  | one result (out_item_t)
//  cfg     | cfg_psel..cfg_pready (APB)     | cpu_count at offset 0x0
//
// A beat passes the request register, then the result register; one beat per cycle
// sustained while out_ready is high. The request register matches the registered
// read of the last-CPU RAM. After reset a clearing pass zeroes the RAM, in_ready low.
// Output stall holds the request stage; a new beat enters as the held one leaves.
module interrupt_target_router
  import irt_pkg::*;
#(
  parameter int NUM_SOURCES = 256,
  parameter int MAX_CPUS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CPUS);
  localparam logic [AW-1:0] LastAddr = AW'(NUM_SOURCES - 1);

  logic [CntW-1:0] cpu_count_r;
  logic            clr_active_r;
  logic [AW-1:0]   clr_idx_r;
  logic            s1_valid_r;
  in_item_t        s1_item_r;
  logic            out_valid_r;
  out_item_t       out_item_r;
  logic            wb_valid_r;
  logic [AW-1:0]   wb_addr_r;
  logic [CpuIdxW-1:0] wb_data_r;

  logic            in_accept;
  logic            s1_advance;
  logic            cfg_write;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [CpuIdxW-1:0] ram_wdata;
  logic [CpuIdxW-1:0] ram_rdata;

  logic [AW-1:0]   s1_addr;
  logic            in_range;
  logic [CpuIdxW-1:0] prev_cpu;
  logic [CntW-1:0] count_eff;
  logic [CpuW-1:0] low_mask;
  logic [CpuW-1:0] cand;
  logic [CntW-1:0] start;
  logic [CpuW-1:0] below_start;
  logic [CpuW-1:0] cand_hi;
  logic [CpuW-1:0] scan;
  logic [CpuW-1:0] pick;
  logic [CpuIdxW-1:0] pick_pos;
  logic            rr_write;
  out_item_t       result;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CPU_COUNT) ? 32'(cpu_count_r) : 32'd0;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !clr_active_r && (!s1_valid_r || s1_advance);
  assign in_accept  = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_item_r;

  // Routing of the request held in stage one
  assign s1_addr  = AW'(s1_item_r.source_index);
  assign in_range = 32'(s1_item_r.source_index) < 32'(NUM_SOURCES);
  assign prev_cpu = !in_range ? '0 :
                    (wb_valid_r && wb_addr_r == s1_addr) ? wb_data_r : ram_rdata;

  always_comb begin
    count_eff = cpu_count_r;
    if (count_eff == '0) begin
      count_eff = CntW'(1);
    end
    if (count_eff > MaxCnt) begin
      count_eff = MaxCnt;
    end
  end

  assign low_mask    = CpuW'((33'd1 << count_eff) - 33'd1);
  assign cand        = s1_item_r.dest_mask & low_mask;
  assign start       = (CntW'(prev_cpu) + CntW'(1) >= count_eff) ? '0 :
                       CntW'(prev_cpu) + CntW'(1);
  assign below_start = CpuW'((33'd1 << start) - 33'd1);
  assign cand_hi     = cand & ~below_start;
  assign scan        = (cand_hi != '0) ? cand_hi : cand;
  assign pick        = scan & (~scan + CpuW'(1));

  always_comb begin
    pick_pos = '0;
    for (int i = 0; i < CpuW; i++) begin
      if (pick[i]) begin
        pick_pos = pick_pos | CpuIdxW'(i);
      end
    end
  end

  always_comb begin
    result.deliver_mask = '0;
    result.status       = STATUS_ROUTED;
    rr_write            = 1'b0;
    priority if (!s1_item_r.pending) begin
      result.status = STATUS_NOT_PENDING;
    end else if (s1_item_r.masked) begin
      result.status = STATUS_MASKED;
    end else if (s1_item_r.priority_req == '0) begin
      result.status = STATUS_ZERO_PRIO;
    end else if (s1_item_r.active) begin
      result.status = STATUS_ACTIVE;
    end else if (s1_item_r.dest_mask == '0) begin
      result.status = STATUS_NO_TARGET;
    end else if (s1_item_r.dest_mask == (CpuW'(1) << prev_cpu)) begin
      result.deliver_mask = s1_item_r.dest_mask;
    end else if (!s1_item_r.distributed) begin
      result.deliver_mask = cand;
    end else begin
      result.deliver_mask = pick;
      rr_write            = (cand != '0) && in_range;
    end
  end

  // RAM write: clearing pass or round-robin update
  assign ram_we    = clr_active_r || (s1_advance && rr_write);
  assign ram_waddr = clr_active_r ? clr_idx_r : s1_addr;
  assign ram_wdata = clr_active_r ? '0 : pick_pos;

  irt_ram #(
    .WIDTH (CpuIdxW),
    .DEPTH (NUM_SOURCES)
  ) u_last_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (AW'(in_data.source_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_count_r  <= CntW'(1);
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      wb_valid_r   <= 1'b0;
    end else begin
      if (cfg_write && cfg_paddr[2] == REG_CPU_COUNT) begin
        cpu_count_r <= cfg_pwdata[CntW-1:0];
      end
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == LastAddr) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (!clr_active_r && s1_advance && rr_write) begin
        wb_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_advance) begin
      out_item_r <= result;
    end
    if (s1_advance && rr_write) begin
      wb_addr_r <= s1_addr;
      wb_data_r <= pick_pos;
    end
  end

endmodule

// File: dv/irt_checker.sv
// Scoreboard for the interrupt target router: tracks cpu_count writes and the
// per-source last CPU, predicts each routing result and compares it on the out beat.
// Depends on irt_pkg.
module irt_checker
  import irt_pkg::*;
#(
  parameter int NUM_SOURCES = 256,
  parameter int MAX_CPUS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_routes
);

  localparam logic [2:0] CPU_COUNT_ADDR = {REG_CPU_COUNT, 2'b00};

  logic [CpuIdxW-1:0] prev_tgt [NUM_SOURCES];
  logic [CntW-1:0]    cpu_cnt;
  out_item_t          routes_due [$];

  function automatic out_item_t route(input in_item_t req);
    out_item_t       res;
    int unsigned     cnt;
    int unsigned     pos;
    logic [4:0]      last;
    logic [CpuW-1:0] below;
    logic            found;
    logic            known;
    res.deliver_mask = '0;
    res.status = STATUS_ROUTED;
    known = req.source_index < NUM_SOURCES;
    last = known ? prev_tgt[req.source_index] : '0;
    cnt = (cpu_cnt == 0) ? 1 : cpu_cnt;
    if (cnt > MAX_CPUS) cnt = MAX_CPUS;
    if (cnt > 32) cnt = 32;
    below = (cnt >= 32) ? '1 : ((32'd1 << cnt) - 32'd1);
    found = 1'b0;
    if (!req.pending) begin
      res.status = STATUS_NOT_PENDING;
    end else if (req.masked) begin
      res.status = STATUS_MASKED;
    end else if (req.priority_req == 0) begin
      res.status = STATUS_ZERO_PRIO;
    end else if (req.active) begin
      res.status = STATUS_ACTIVE;
    end else if (req.dest_mask == 0) begin
      res.status = STATUS_NO_TARGET;
    end else if (req.dest_mask == (32'd1 << last)) begin
      res.deliver_mask = req.dest_mask;
    end else if (!req.distributed) begin
      res.deliver_mask = req.dest_mask & below;
    end else begin
      // round-robin: start after last CPU, last CPU itself is the final candidate
      pos = last + 1;
      if (pos >= cnt) pos = 0;
      for (int k = 0; k < cnt; k++) begin
        if (!found && req.dest_mask[pos]) begin
          found = 1'b1;
          res.deliver_mask = 32'd1 << pos;
          if (known) prev_tgt[req.source_index] = pos[CpuIdxW-1:0];
        end
        pos = pos + 1;
        if (pos >= cnt) pos = 0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) prev_tgt[i] = '0;
      cpu_cnt = 6'd1;
      routes_due.delete();
      pending_routes = 0;
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == CPU_COUNT_ADDR)
        cpu_cnt = cfg_pwdata[CntW-1:0];
      if (out_valid && out_ready) begin
        if (routes_due.size() == 0) begin
          $error("unexpected out beat: deliver_mask %h status %0d",
                 out_data.deliver_mask, out_data.status);
          fail_count++;
        end else begin
          want = routes_due.pop_front();
          if (out_data.deliver_mask !== want.deliver_mask) begin
            $error("deliver_mask expected %h actual %h", want.deliver_mask,
                   out_data.deliver_mask);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) routes_due.push_back(route(in_data));
      pending_routes = routes_due.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Top of the interrupt target router testbench: clock, reset, APB writes of cpu_count,
// directed and random request beats, random output backpressure and the verdict.
// Depends on irt_pkg, irt_checker and interrupt_target_router.
module tb_top;
  import irt_pkg::*;

  localparam int         NUM_SOURCES    = 256;
  localparam int         MAX_CPUS       = 32;
  localparam int         ITEM_TARGET    = 1650;
  localparam int         STALL_LIMIT    = 4000;
  localparam logic [2:0] CPU_COUNT_ADDR = {REG_CPU_COUNT, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending_routes;
  int          stall_cycles = 0;
  bit          steady = 1'b1;

  interrupt_target_router #(
    .NUM_SOURCES(NUM_SOURCES),
    .MAX_CPUS   (MAX_CPUS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  irt_checker #(
    .NUM_SOURCES(NUM_SOURCES),
    .MAX_CPUS   (MAX_CPUS)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_routes(pending_routes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic in_item_t make_req(input logic [7:0] idx, input logic pend,
                                        input logic msk, input logic [3:0] prio,
                                        input logic act, input logic spread,
                                        input logic [31:0] dest);
    in_item_t r;
    r.source_index = idx;
    r.pending      = pend;
    r.masked       = msk;
    r.priority_req = prio;
    r.active       = act;
    r.distributed  = spread;
    r.dest_mask    = dest;
    return r;
  endfunction

  task automatic send_req(input in_item_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_routes != 0) @(negedge clk);
  endtask

  task automatic write_cpu_count(input logic [CntW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CPU_COUNT_ADDR;
    cfg_pwdata  <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // result side backpressure
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL interrupt_target_router");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          phase_len;
    logic [5:0]  cnt;
    logic [31:0] dest;
    logic [7:0]  idx;
    logic        good;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sent        = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of one: each reject reason, checked in priority order, then two routed requests
    send_req(make_req(8'd0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_req(make_req(8'd1, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(8'd2, 1'b1, 1'b0, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_req(make_req(8'd3, 1'b1, 1'b0, 4'd15, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(8'd255, 1'b1, 1'b0, 4'd15, 1'b0, 1'b1, 32'h0));
    send_req(make_req(8'd4, 1'b1, 1'b0, 4'd1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(8'd5, 1'b1, 1'b0, 4'd1, 1'b0, 1'b1, 32'hFFFF_FFFE));
    drain();
    write_cpu_count(6'd32);
    send_req(make_req(8'd255, 1'b1, 1'b0, 4'd15, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(8'd10, 1'b1, 1'b0, 4'd7, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_req(make_req(8'd10, 1'b1, 1'b0, 4'd7, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_req(make_req(8'd10, 1'b1, 1'b0, 4'd7, 1'b0, 1'b1, 32'h8000_0000));
    send_req(make_req(8'd10, 1'b1, 1'b0, 4'd7, 1'b0, 1'b1, 32'h0000_0003));
    send_req(make_req(8'd10, 1'b1, 1'b0, 4'd7, 1'b0, 1'b1, 32'h0000_0001));
    drain();
    write_cpu_count(6'd8);
    send_req(make_req(8'd20, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_0040));
    drain();
    write_cpu_count(6'd4);
    // single bit of last CPU above the count, then wrap from it
    send_req(make_req(8'd20, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_0040));
    send_req(make_req(8'd20, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_0041));
    // nothing below the count
    send_req(make_req(8'd21, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_00F0));
    send_req(make_req(8'd21, 1'b1, 1'b0, 4'd3, 1'b0, 1'b0, 32'hFFFF_FFF0));
    // last CPU itself as final candidate
    send_req(make_req(8'd22, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_0005));
    send_req(make_req(8'd22, 1'b1, 1'b0, 4'd3, 1'b0, 1'b1, 32'h0000_0104));
    drain();
    write_cpu_count(6'd0);
    send_req(make_req(8'd23, 1'b1, 1'b0, 4'd9, 1'b0, 1'b0, 32'hFFFF_FFFF));
    drain();
    write_cpu_count(6'd63);
    send_req(make_req(8'd24, 1'b1, 1'b0, 4'd9, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(8'd24, 1'b1, 1'b0, 4'd9, 1'b0, 1'b1, 32'h8000_0000));
    drain();

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       cnt = 6'd0;
        1:       cnt = 6'd1;
        2:       cnt = 6'd32;
        3:       cnt = 6'd63;
        4:       cnt = 6'($urandom_range(33, 62));
        default: cnt = 6'($urandom_range(1, 32));
      endcase
      write_cpu_count(cnt);
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 160);
      for (int n = 0; n < phase_len; n++) begin
        case ($urandom_range(0, 5))
          0:       dest = $urandom;
          1:       dest = $urandom & 32'h0000_00FF;
          2:       dest = 32'd1 << $urandom_range(0, 31);
          3:       dest = (32'd1 << $urandom_range(0, 3)) | (32'd1 << $urandom_range(0, 7));
          4:       dest = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          default: dest = $urandom & $urandom;
        endcase
        idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        good = ($urandom_range(0, 99) < 85);
        if (good)
          send_req(make_req(idx, 1'b1, 1'b0, 4'($urandom_range(1, 15)), 1'b0,
                            1'($urandom_range(0, 1)), dest));
        else
          send_req(make_req(idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), dest));
        sent++;
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_routes == 0) begin
      $display("PASS interrupt_target_router");
    end else begin
      $display("FAIL interrupt_target_router");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/irt_pkg.sv
sv/irt_ram.sv
sv/interrupt_target_router.sv
dv/irt_checker.sv
dv/tb_top.sv
